### design/rpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rpc_pkg;

  localparam int ROW_W  = 32;
  localparam int SIZE_W = 6;
  localparam int DATA_W = 32;
  localparam int ADDR_W = 3;

  localparam logic REG_MATRIX_SIZE = 1'b0;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

  typedef struct packed {
    logic refl_fail;
    logic sym_fail;
    logic anti_fail;
    logic trans_fail;
  } lane_flags_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } check_ctl_t;

endpackage
`default_nettype wire

### design/rpc_lane.sv
`timescale 1ns / 1ps
`default_nettype none
module rpc_lane #(
  parameter int LANE  = 0,
  parameter int IDX_W = 5
) (
  input  wire logic [rpc_pkg::ROW_W-1:0]  lane_row,
  input  wire logic [rpc_pkg::ROW_W-1:0]  cur_row,
  input  wire logic [IDX_W-1:0]           cur_idx,
  input  wire logic [rpc_pkg::SIZE_W-1:0] n_use,
  output rpc_pkg::lane_flags_t            flags
);
  import rpc_pkg::*;

  logic active;
  logic on_diag;
  logic a_bit;
  logic b_bit;

  always_comb begin
    active  = SIZE_W'(LANE) < n_use;
    on_diag = IDX_W'(LANE) == cur_idx;
    // a is entry (i, lane), b is entry (lane, i)
    a_bit   = cur_row[LANE];
    b_bit   = lane_row[cur_idx];
    flags.refl_fail  = active && on_diag && !a_bit;
    flags.sym_fail   = active && (a_bit != b_bit);
    flags.anti_fail  = active && !on_diag && a_bit && b_bit;
    flags.trans_fail = active && a_bit && (|(lane_row & ~cur_row));
  end

endmodule
`default_nettype wire

### design/rpc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
module rpc_merge #(
  parameter int NUM_LANES = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rpc_pkg::check_ctl_t  ctl,
  input  wire rpc_pkg::lane_flags_t lane_flags [NUM_LANES],
  output logic                      done,
  output logic                      reflexive,
  output logic                      symmetric,
  output logic                      antisymmetric,
  output logic                      transitive
);
  import rpc_pkg::*;

  lane_flags_t any_fail;
  lane_flags_t fail_acc;
  lane_flags_t fail_acc_next;
  lane_flags_t result;

  always_comb begin
    any_fail = '0;
    for (int l = 0; l < NUM_LANES; l++) begin
      any_fail = lane_flags_t'(any_fail | lane_flags[l]);
    end
    fail_acc_next = lane_flags_t'((ctl.first ? lane_flags_t'('0) : fail_acc) | any_fail);
  end

  always_ff @(posedge clk) begin
    if (ctl.valid) begin
      fail_acc <= fail_acc_next;
    end
    if (ctl.valid && ctl.last) begin
      result <= fail_acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.valid && ctl.last;
    end
  end

  assign reflexive     = !result.refl_fail;
  assign symmetric     = !result.sym_fail;
  assign antisymmetric = !result.anti_fail;
  assign transitive    = !result.trans_fail;

endmodule
`default_nettype wire

### design/relation_property_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// Relation property checker. Rows of an n by n 0/1 matrix go in one word per
// cycle while busy is low, on start/row_bits, row 0 first; bits at or above n
// are dropped. Once row n-1 is taken the block raises busy: one stored row a
// cycle is read out and compared against every row at once by one lane per
// column, and a merge stage folds the lane results. The four flags appear with
// done for one cycle, the last cycle of busy, and cannot be held off. n comes
// from matrix_size (0 reads as 1, values above the lane count saturate);
// writing it drops a partly received matrix.
module relation_property_checker #(
  parameter int MAX_SIZE = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [rpc_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [rpc_pkg::DATA_W-1:0]  pwdata,
  output logic      [rpc_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [rpc_pkg::ROW_W-1:0]   row_bits,
  output logic                             done,
  output logic                             reflexive,
  output logic                             symmetric,
  output logic                             antisymmetric,
  output logic                             transitive
);
  import rpc_pkg::*;

  localparam int NUM_LANES = (MAX_SIZE < ROW_W) ? MAX_SIZE : ROW_W;
  localparam int IDX_W     = $clog2(NUM_LANES);

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [SIZE_W-1:0] matrix_size;
  logic [SIZE_W-1:0] n_use;
  logic [SIZE_W-1:0] n_last;
  logic [ROW_W-1:0]  row_mask;
  logic [IDX_W-1:0]  rows_received;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  cur_idx;
  logic [ROW_W-1:0]  cur_row;
  check_ctl_t        ctl;
  check_ctl_t        ctl_next;
  logic              cfg_write;
  logic              accept;
  logic              last_row;
  logic              rd_last;

  logic [ROW_W-1:0]  row_store [NUM_LANES];
  lane_flags_t       lane_flags [NUM_LANES];

  // config port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_MATRIX_SIZE);
  assign prdata    = (paddr[2] == REG_MATRIX_SIZE) ? DATA_W'(matrix_size) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= SIZE_RESET;
    end else if (cfg_write) begin
      matrix_size <= pwdata[SIZE_W-1:0];
    end
  end

  always_comb begin
    if (matrix_size == '0) begin
      n_use = SIZE_W'(1);
    end else if (matrix_size > SIZE_W'(NUM_LANES)) begin
      n_use = SIZE_W'(NUM_LANES);
    end else begin
      n_use = matrix_size;
    end
    n_last = n_use - SIZE_W'(1);
    for (int j = 0; j < ROW_W; j++) begin
      row_mask[j] = SIZE_W'(j) < n_use;
    end
  end

  // row intake
  assign busy     = (state != S_LOAD);
  assign accept   = start && !busy;
  assign last_row = SIZE_W'(rows_received) == n_last;
  assign rd_last  = SIZE_W'(rd_idx) == n_last;

  always_ff @(posedge clk) begin
    if (accept) begin
      row_store[rows_received] <= row_bits & row_mask;
    end
    cur_row <= row_store[rd_idx];
    cur_idx <= rd_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_received <= '0;
    end else if (cfg_write || (accept && last_row)) begin
      rows_received <= '0;
    end else if (accept) begin
      rows_received <= rows_received + IDX_W'(1);
    end
  end

  // check sequencer
  always_comb begin
    state_next     = state;
    ctl_next       = '0;
    case (state)
      S_LOAD: begin
        if (accept && last_row) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        ctl_next.valid = 1'b1;
        ctl_next.first = (rd_idx == '0);
        ctl_next.last  = rd_last;
        if (rd_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (done) begin
          state_next = S_LOAD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      rd_idx <= '0;
      ctl    <= '0;
    end else begin
      state <= state_next;
      ctl   <= ctl_next;
      if (state == S_READ && !rd_last) begin
        rd_idx <= rd_idx + IDX_W'(1);
      end else if (state != S_READ) begin
        rd_idx <= '0;
      end
    end
  end

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    rpc_lane #(
      .LANE  (l),
      .IDX_W (IDX_W)
    ) u_lane (
      .lane_row (row_store[l]),
      .cur_row  (cur_row),
      .cur_idx  (cur_idx),
      .n_use    (n_use),
      .flags    (lane_flags[l])
    );
  end

  rpc_merge #(
    .NUM_LANES (NUM_LANES)
  ) u_merge (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .lane_flags    (lane_flags),
    .done          (done),
    .reflexive     (reflexive),
    .symmetric     (symmetric),
    .antisymmetric (antisymmetric),
    .transitive    (transitive)
  );

  a_done_in_drain: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_DRAIN)
    else $error("done outside drain");

  a_done_ends_busy: assert property (@(posedge clk) disable iff (rst)
    done |=> state == S_LOAD)
    else $error("busy held after result");

  a_last_row_starts_check: assert property (@(posedge clk) disable iff (rst)
    (accept && last_row) |=> (state == S_READ && rd_idx == '0))
    else $error("check did not start after last row");

  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_LOAD |-> SIZE_W'(rows_received) < n_use)
    else $error("row count beyond matrix size");

  a_read_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_READ |-> SIZE_W'(rd_idx) < n_use)
    else $error("read index beyond matrix size");

endmodule
`default_nettype wire

### dv/tb_relation_property_checker.sv
`timescale 1ns / 1ps
module tb_relation_property_checker;
  import rpc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 40;
  localparam int REG_UNUSED = 1;
  localparam logic [ADDR_W-1:0] ADDR_SIZE = ADDR_W'(4 * REG_MATRIX_SIZE);
  localparam logic [ADDR_W-1:0] ADDR_UNUSED = ADDR_W'(4 * REG_UNUSED);

  typedef struct packed {
    logic refl;
    logic sym;
    logic anti;
    logic trans;
  } relation_flags_t;

  typedef enum int {
    REL_RANDOM, REL_SPARSE, REL_EMPTY, REL_FULL, REL_IDENTITY, REL_EQUIV, REL_ORDER, REL_SYMM
  } rel_kind_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic start = 1'b0;
  logic busy;
  logic [ROW_W-1:0] row_bits = '0;
  logic done;
  logic reflexive, symmetric, antisymmetric, transitive;

  relation_property_checker uut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .start(start), .busy(busy), .row_bits(row_bits),
    .done(done), .reflexive(reflexive), .symmetric(symmetric),
    .antisymmetric(antisymmetric), .transitive(transitive)
  );

  always #2 clk = ~clk;

  // predictor state
  logic [SIZE_W-1:0] size_code;
  logic [ROW_W-1:0] row_store [0:ROW_W-1];
  int rows_taken;

  logic [ROW_W-1:0] rows_pending [$];
  relation_flags_t flags_due [$];
  int rows_pushed = 0;
  int rows_accepted = 0;
  int fails = 0;
  int cycles = 0;
  int idle_pct = 0;
  logic took = 1'b0;

  function automatic int size_in_effect(logic [SIZE_W-1:0] code);
    int n;
    n = int'(code);
    if (n == 0) n = 1;
    if (n > ROW_W) n = ROW_W;
    return n;
  endfunction

  function automatic logic [ROW_W-1:0] col_mask(int n);
    return (n >= ROW_W) ? '1 : ((ROW_W'(1) << n) - 1);
  endfunction

  function automatic relation_flags_t judge_relation(int n);
    relation_flags_t f;
    logic a, b;
    f = '1;
    for (int i = 0; i < n; i++) begin
      if (!row_store[i][i]) f.refl = 1'b0;
      for (int j = 0; j < n; j++) begin
        a = row_store[i][j];
        b = row_store[j][i];
        if (a != b) f.sym = 1'b0;
        if (i != j && a && b) f.anti = 1'b0;
        if (a && ((row_store[j] & ~row_store[i]) != '0)) f.trans = 1'b0;
      end
    end
    return f;
  endfunction

  task automatic take_row(logic [ROW_W-1:0] word);
    int n;
    n = size_in_effect(size_code);
    if (rows_taken >= n) rows_taken = 0;
    row_store[rows_taken] = word & col_mask(n);
    rows_taken++;
    if (rows_taken == n) begin
      rows_taken = 0;
      flags_due.push_back(judge_relation(n));
    end
  endtask

  // driver: a word stays on the bus until it is taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (rows_pending.size() > 0 && $urandom_range(99, 0) >= idle_pct) begin
        start <= 1'b1;
        row_bits <= rows_pending.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    relation_flags_t want;
    if (rst) begin
      size_code = SIZE_RESET;
      rows_taken = 0;
      took <= 1'b0;
    end else begin
      if (done) begin
        if (flags_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %b%b%b%b", $time,
                   reflexive, symmetric, antisymmetric, transitive);
          fails++;
        end else begin
          want = flags_due.pop_front();
          if (reflexive !== want.refl) begin
            $display("%0t: reflexive expected %0b got %0b", $time, want.refl, reflexive);
            fails++;
          end
          if (symmetric !== want.sym) begin
            $display("%0t: symmetric expected %0b got %0b", $time, want.sym, symmetric);
            fails++;
          end
          if (antisymmetric !== want.anti) begin
            $display("%0t: antisymmetric expected %0b got %0b", $time, want.anti,
                     antisymmetric);
            fails++;
          end
          if (transitive !== want.trans) begin
            $display("%0t: transitive expected %0b got %0b", $time, want.trans, transitive);
            fails++;
          end
        end
      end
      if (psel && penable && pwrite && pready && (paddr >> 2) == ADDR_W'(REG_MATRIX_SIZE)) begin
        size_code = pwdata[SIZE_W-1:0];
        rows_taken = 0;
      end
      if (start && !busy) begin
        rows_accepted++;
        take_row(row_bits);
      end
      took <= start && !busy;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic tick();
    @(posedge clk);
    #1;
  endtask

  task automatic push_row(logic [ROW_W-1:0] word);
    rows_pending.push_back(word);
    rows_pushed++;
  endtask

  // wait for every word taken and every result back, then let the block drain
  task automatic wait_quiet();
    while (rows_accepted != rows_pushed || flags_due.size() != 0) tick();
    repeat (DRAIN_CYCLES) tick();
  endtask

  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic push_matrix(int n, rel_kind_t kind);
    logic [ROW_W-1:0] m [0:ROW_W-1];
    int lab [0:ROW_W-1];
    int classes, r, c;
    logic [ROW_W-1:0] mask;
    mask = col_mask(n);
    classes = $urandom_range(n, 1);
    for (int i = 0; i < n; i++) lab[i] = $urandom_range(classes - 1, 0);
    for (int i = 0; i < n; i++) begin
      case (kind)
        REL_RANDOM:   m[i] = $urandom();
        REL_SPARSE:   m[i] = $urandom() & $urandom() & $urandom();
        REL_EMPTY:    m[i] = '0;
        REL_FULL:     m[i] = '1;
        REL_IDENTITY: m[i] = ROW_W'(1) << i;
        REL_EQUIV: begin
          m[i] = '0;
          for (int j = 0; j < n; j++) m[i][j] = (lab[i] == lab[j]);
        end
        default: begin
          // upper triangle only, filled out below
          m[i] = '0;
          for (int j = i + 1; j < n; j++) m[i][j] = ($urandom_range(3, 0) == 0);
        end
      endcase
    end
    if (kind == REL_ORDER) begin
      // transitive closure, then reflexive or strict
      for (int k = 0; k < n; k++)
        for (int i = 0; i < n; i++)
          if (m[i][k]) m[i] = m[i] | m[k];
      if ($urandom_range(1, 0)) for (int i = 0; i < n; i++) m[i][i] = 1'b1;
    end else if (kind == REL_SYMM) begin
      for (int i = 0; i < n; i++) begin
        m[i][i] = $urandom_range(3, 0) != 0;
        for (int j = 0; j < i; j++) m[i][j] = m[j][i];
      end
    end
    // near miss: one entry flipped
    if ($urandom_range(3, 0) == 0) begin
      r = $urandom_range(n - 1, 0);
      c = $urandom_range(n - 1, 0);
      m[r][c] = ~m[r][c];
    end
    for (int i = 0; i < n; i++) push_row((m[i] & mask) | ($urandom() & ~mask));
  endtask

  initial begin
    int sizes [16];
    int idles [4];
    int n, phase, phase_start;
    rel_kind_t kind;

    sizes = '{4, 1, 63, 2, 8, 3, 0, 5, 32, 6, 40, 7, 16, 3, 5, 2};
    idles = '{0, 77, 24, 0};

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tick();

    // one column
    reg_write(ADDR_SIZE, 32'd1);
    push_row(32'h0000_0001);
    push_row(32'hFFFF_FFFE);
    push_row(32'h8000_0000);
    wait_quiet();
    // zero size reads as one
    reg_write(ADDR_SIZE, 32'hFFFF_FFC0);
    push_row(32'hFFFF_FFFF);
    push_row(32'h0000_0000);
    wait_quiet();
    reg_write(ADDR_SIZE, 32'd2);
    push_row(32'h0000_0001); push_row(32'h0000_0002);
    push_row(32'h0000_0003); push_row(32'h0000_0003);
    push_row(32'h0000_0002); push_row(32'h0000_0001);
    push_row(32'h0000_0000); push_row(32'h0000_0000);
    push_row(32'hFFFF_FFFE); push_row(32'hFFFF_FFFC);
    wait_quiet();
    // partial matrix dropped by the size write
    reg_write(ADDR_SIZE, 32'd3);
    push_row(32'h0000_0007);
    push_row(32'h0000_0007);
    wait_quiet();
    reg_write(ADDR_UNUSED, 32'hFFFF_FFFF);
    reg_write(ADDR_SIZE, 32'd3);
    push_row(32'h0000_0002);
    push_row(32'h0000_0004);
    push_row(32'hFFFF_FFF8);
    wait_quiet();

    phase = 0;
    while (rows_pushed < 1040) begin
      if ($urandom_range(2, 0) == 0) reg_write(ADDR_UNUSED, $urandom());
      reg_write(ADDR_SIZE, {26'($urandom()), sizes[phase % 16][SIZE_W-1:0]});
      n = size_in_effect(sizes[phase % 16][SIZE_W-1:0]);
      idle_pct = idles[phase % 4];
      phase_start = rows_pushed;
      while (rows_pushed - phase_start < 60) begin
        kind = rel_kind_t'($urandom_range(7, 0));
        push_matrix(n, kind);
      end
      // broken sequence left for the next size write to drop
      if (n > 1 && $urandom_range(2, 0) == 0)
        repeat ($urandom_range(n - 1, 1)) push_row($urandom());
      wait_quiet();
      phase++;
    end

    wait_quiet();
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
